// ----- design/ttfs_pkg.sv -----
package ttfs_pkg;

    localparam int W_VAL  = 24;
    localparam int W_STEP = 16;
    localparam int W_POS  = 40;
    localparam int W_TGT  = 32;

    // Axis codes, shared by the sequencer and the target unit.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Command opcodes.
    localparam logic [1:0] OP_REL_TILT  = 2'd0;
    localparam logic [1:0] OP_ABS_TILT  = 2'd1;
    localparam logic [1:0] OP_REL_FOCUS = 2'd2;
    localparam logic [1:0] OP_ABS_FOCUS = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_FWD_X  = 3'd0;
    localparam logic [2:0] REG_FWD_Y  = 3'd1;
    localparam logic [2:0] REG_FWD_Z  = 3'd2;
    localparam logic [2:0] REG_BACK_X = 3'd3;
    localparam logic [2:0] REG_BACK_Y = 3'd4;
    localparam logic [2:0] REG_BACK_Z = 3'd5;

    localparam logic [15:0] RST_FWD_X  = 16'd5960;
    localparam logic [15:0] RST_FWD_Y  = 16'd5970;
    localparam logic [15:0] RST_FWD_Z  = 16'd6661;
    localparam logic [15:0] RST_BACK_X = 16'd5146;
    localparam logic [15:0] RST_BACK_Y = 16'd5105;
    localparam logic [15:0] RST_BACK_Z = 16'd5745;

    // Mapping constants, Q0.16.
    localparam logic [15:0] K_TWO_THIRDS = 16'd43691;
    localparam logic [15:0] K_ONE_THIRD  = 16'd21845;
    localparam logic [15:0] K_TAN30      = 16'd37837;

    localparam logic signed [23:0] V24_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] V24_MIN = 24'sh800000;
    localparam logic signed [39:0] P40_MAX = 40'sh7FFFFFFFFF;
    localparam logic signed [39:0] P40_MIN = 40'sh8000000000;

    typedef struct packed {
        logic [2:0][15:0] fwd;
        logic [2:0][15:0] back;
    } t_step_cfg;

    typedef struct packed {
        logic       start;
        logic [1:0] axis;
    } t_mac_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] target;
    } t_mac_res;

    typedef struct packed {
        logic               done;
        logic signed [23:0] steps;
        logic [15:0]        size;
    } t_div_res;

endpackage

// ----- design/tip_tilt_focus_stepper.sv -----
// Tip, tilt and focus stepper for a three-actuator mount.
//
// Commands arrive on the input channel (i_in_valid / o_in_ready) as an opcode
// with one or two Q15.8 values; each command yields exactly one result beat of
// three signed step counts on the output channel (o_out_valid / i_out_ready).
// The user must set step sizes via the APB port only while idle; it is unchecked.
//
// One command is processed at a time. The three actuators are handled in turn
// by one shared datapath: a constant multiplier forms the target, and a
// restoring divider forms the step count, one bit per cycle. The result beat
// appears once all three actuators are done, and the block is ready for the
// next command in the same cycle as that beat appears.
//
// The result sits in an output register; a new command is taken while it waits.
// If the receiver still stalls when the next result is ready, the block holds
// in its output state and accepts nothing further until the old beat is taken.
// Reset returns the step sizes to their defaults and clears the angles, focus
// and tracked positions; no results are pending afterwards.
module tip_tilt_focus_stepper (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_opcode,
    input  logic signed [23:0] i_value_a,
    input  logic signed [23:0] i_value_b,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [23:0] o_steps_x,
    output logic signed [23:0] o_steps_y,
    output logic signed [23:0] o_steps_z,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_MAC_GO   = 3'd1;
    localparam logic [2:0] S_MAC_WAIT = 3'd2;
    localparam logic [2:0] S_DIV_GO   = 3'd3;
    localparam logic [2:0] S_DIV_WAIT = 3'd4;
    localparam logic [2:0] S_MUL      = 3'd5;
    localparam logic [2:0] S_POS      = 3'd6;
    localparam logic [2:0] S_OUT      = 3'd7;

    ttfs_pkg::t_step_cfg w_cfg;
    ttfs_pkg::t_mac_req  w_mac_req;
    ttfs_pkg::t_mac_res  w_mac_res;
    ttfs_pkg::t_div_res  w_div_res;

    logic [2:0]                r_state;
    logic [1:0]                r_axis;
    logic signed [23:0]        r_alpha;
    logic signed [23:0]        r_beta;
    logic signed [23:0]        r_focus;
    logic signed [2:0][39:0]   r_pos;
    logic signed [2:0][23:0]   r_steps;
    logic signed [23:0]        r_cur_steps;
    logic [15:0]               r_cur_size;
    logic signed [39:0]        r_prod;
    logic                      r_out_valid;
    logic signed [23:0]        r_out_x;
    logic signed [23:0]        r_out_y;
    logic signed [23:0]        r_out_z;

    logic                      w_accept;
    logic                      w_load_out;
    logic signed [39:0]        w_cur_pos;
    logic signed [40:0]        w_prod;
    logic signed [40:0]        w_pos_sum;
    logic signed [39:0]        w_pos_nx;
    logic signed [23:0]        w_alpha_nx;
    logic signed [23:0]        w_beta_nx;
    logic signed [23:0]        w_focus_nx;

    function automatic logic signed [23:0] sat_add24(input logic signed [23:0] acc,
                                                     input logic signed [23:0] delta);
        logic signed [24:0] sum;
        sum = {acc[23], acc} + {delta[23], delta};
        if (sum[24] != sum[23]) begin
            sat_add24 = sum[24] ? ttfs_pkg::V24_MIN : ttfs_pkg::V24_MAX;
        end else begin
            sat_add24 = sum[23:0];
        end
    endfunction

    ttfs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_mac_req.start = (r_state == S_MAC_GO);
    assign w_mac_req.axis  = r_axis;

    ttfs_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mac_req),
        .i_alpha (r_alpha),
        .i_beta  (r_beta),
        .i_focus (r_focus),
        .o_res   (w_mac_res)
    );

    assign w_cur_pos = r_pos[r_axis];

    ttfs_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_DIV_GO),
        .i_target (w_mac_res.target),
        .i_pos    (w_cur_pos),
        .i_fwd    (w_cfg.fwd[r_axis]),
        .i_back   (w_cfg.back[r_axis]),
        .o_res    (w_div_res)
    );

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load_out = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        w_alpha_nx = r_alpha;
        w_beta_nx  = r_beta;
        w_focus_nx = r_focus;
        unique case (i_opcode)
            ttfs_pkg::OP_REL_TILT: begin
                w_alpha_nx = sat_add24(r_alpha, i_value_a);
                w_beta_nx  = sat_add24(r_beta, i_value_b);
            end
            ttfs_pkg::OP_ABS_TILT: begin
                w_alpha_nx = i_value_a;
                w_beta_nx  = i_value_b;
            end
            ttfs_pkg::OP_REL_FOCUS: w_focus_nx = sat_add24(r_focus, i_value_a);
            ttfs_pkg::OP_ABS_FOCUS: w_focus_nx = i_value_a;
        endcase
    end

    assign w_prod    = r_cur_steps * $signed({1'b0, r_cur_size});
    assign w_pos_sum = {w_cur_pos[39], w_cur_pos} + {r_prod[39], r_prod};
    assign w_pos_nx  = (w_pos_sum[40] != w_pos_sum[39])
                     ? (w_pos_sum[40] ? ttfs_pkg::P40_MIN : ttfs_pkg::P40_MAX)
                     : w_pos_sum[39:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= ttfs_pkg::AXIS_X;
            r_alpha     <= 24'sd0;
            r_beta      <= 24'sd0;
            r_focus     <= 24'sd0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_alpha <= w_alpha_nx;
                        r_beta  <= w_beta_nx;
                        r_focus <= w_focus_nx;
                        r_axis  <= ttfs_pkg::AXIS_X;
                        r_state <= S_MAC_GO;
                    end
                end
                S_MAC_GO: r_state <= S_MAC_WAIT;
                S_MAC_WAIT: begin
                    if (w_mac_res.done) begin
                        r_state <= S_DIV_GO;
                    end
                end
                S_DIV_GO: r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (w_div_res.done) begin
                        r_steps[r_axis] <= w_div_res.steps;
                        r_cur_steps     <= w_div_res.steps;
                        r_cur_size      <= w_div_res.size;
                        r_state         <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_prod[39:0];
                    r_state <= S_POS;
                end
                S_POS: begin
                    r_pos[r_axis] <= w_pos_nx;
                    if (r_axis == ttfs_pkg::AXIS_Z) begin
                        r_state <= S_OUT;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= S_MAC_GO;
                    end
                end
                S_OUT: begin
                    if (w_load_out) begin
                        r_out_x     <= r_steps[0];
                        r_out_y     <= r_steps[1];
                        r_out_z     <= r_steps[2];
                        r_state     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_steps_x   = r_out_x;
    assign o_steps_y   = r_out_y;
    assign o_steps_z   = r_out_z;

    a_mac_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_res.done |-> r_state == S_MAC_WAIT)
        else $error("target unit finished outside its wait state");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_res.done |-> r_state == S_DIV_WAIT)
        else $error("divider finished outside its wait state");

    a_accept_starts_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_MAC_GO) && (r_axis == ttfs_pkg::AXIS_X))
        else $error("accepted command did not start on actuator one");

    a_axis_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_axis <= ttfs_pkg::AXIS_Z))
        else $error("actuator index out of range");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> o_out_valid && (r_state == S_IDLE))
        else $error("finished result was not presented");

endmodule

// ----- design/ttfs_regs.sv -----
module ttfs_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output ttfs_pkg::t_step_cfg  o_cfg
);

    logic [2:0][15:0] r_fwd;
    logic [2:0][15:0] r_back;
    logic [2:0]       w_index;
    logic [15:0]      w_rdata;

    assign w_index = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd[0]  <= ttfs_pkg::RST_FWD_X;
            r_fwd[1]  <= ttfs_pkg::RST_FWD_Y;
            r_fwd[2]  <= ttfs_pkg::RST_FWD_Z;
            r_back[0] <= ttfs_pkg::RST_BACK_X;
            r_back[1] <= ttfs_pkg::RST_BACK_Y;
            r_back[2] <= ttfs_pkg::RST_BACK_Z;
        end else if (psel && penable && pwrite) begin
            unique case (w_index)
                ttfs_pkg::REG_FWD_X:  r_fwd[0]  <= pwdata[15:0];
                ttfs_pkg::REG_FWD_Y:  r_fwd[1]  <= pwdata[15:0];
                ttfs_pkg::REG_FWD_Z:  r_fwd[2]  <= pwdata[15:0];
                ttfs_pkg::REG_BACK_X: r_back[0] <= pwdata[15:0];
                ttfs_pkg::REG_BACK_Y: r_back[1] <= pwdata[15:0];
                ttfs_pkg::REG_BACK_Z: r_back[2] <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            ttfs_pkg::REG_FWD_X:  w_rdata = r_fwd[0];
            ttfs_pkg::REG_FWD_Y:  w_rdata = r_fwd[1];
            ttfs_pkg::REG_FWD_Z:  w_rdata = r_fwd[2];
            ttfs_pkg::REG_BACK_X: w_rdata = r_back[0];
            ttfs_pkg::REG_BACK_Y: w_rdata = r_back[1];
            ttfs_pkg::REG_BACK_Z: w_rdata = r_back[2];
            default:              w_rdata = 16'd0;
        endcase
    end

    assign prdata     = {16'd0, w_rdata};
    assign o_cfg.fwd  = r_fwd;
    assign o_cfg.back = r_back;

endmodule

// ----- design/ttfs_mac.sv -----
module ttfs_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ttfs_pkg::t_mac_req  i_req,
    input  logic signed [23:0]  i_alpha,
    input  logic signed [23:0]  i_beta,
    input  logic signed [23:0]  i_focus,
    output ttfs_pkg::t_mac_res  o_res
);

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_MUL  = 3'd1;
    localparam logic [2:0] M_FOC  = 3'd2;
    localparam logic [2:0] M_SCL  = 3'd3;
    localparam logic [2:0] M_RND  = 3'd4;
    localparam logic [2:0] M_DONE = 3'd5;

    localparam logic signed [47:0] RND_POS = 48'sd32768;
    localparam logic signed [47:0] RND_NEG = 48'sd32767;

    logic [2:0]         r_state;
    logic [3:0]         r_cnt;
    logic [15:0]        r_ka;
    logic [15:0]        r_kb;
    logic signed [24:0] r_op_a;
    logic signed [24:0] r_op_b;
    logic signed [23:0] r_focus;
    logic signed [47:0] r_acc;
    logic signed [31:0] r_target;

    logic signed [24:0] w_a25;
    logic signed [24:0] w_b25;
    logic signed [47:0] w_term_a;
    logic signed [47:0] w_term_b;
    logic signed [47:0] w_round;

    assign w_a25    = {i_alpha[23], i_alpha};
    assign w_b25    = {i_beta[23], i_beta};
    assign w_term_a = r_ka[15] ? {{23{r_op_a[24]}}, r_op_a} : 48'sd0;
    assign w_term_b = r_kb[15] ? {{23{r_op_b[24]}}, r_op_b} : 48'sd0;
    // Half away from zero: negative values take one less before the floor shift.
    assign w_round  = r_acc + (r_acc[47] ? RND_NEG : RND_POS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            unique case (r_state)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_state <= M_MUL;
                        r_cnt   <= 4'd15;
                        r_acc   <= 48'sd0;
                        r_focus <= i_focus;
                        if (i_req.axis == ttfs_pkg::AXIS_X) begin
                            r_ka   <= ttfs_pkg::K_TWO_THIRDS;
                            r_kb   <= 16'd0;
                            r_op_a <= w_a25;
                        end else begin
                            r_ka   <= ttfs_pkg::K_ONE_THIRD;
                            r_kb   <= ttfs_pkg::K_TAN30;
                            r_op_a <= 25'sd0 - w_a25;
                        end
                        r_op_b <= (i_req.axis == ttfs_pkg::AXIS_Z) ? 25'sd0 - w_b25 : w_b25;
                    end
                end
                M_MUL: begin
                    // One constant bit a cycle, most significant first.
                    r_acc <= {r_acc[46:0], 1'b0} + w_term_a + w_term_b;
                    r_ka  <= {r_ka[14:0], 1'b0};
                    r_kb  <= {r_kb[14:0], 1'b0};
                    r_cnt <= r_cnt - 4'd1;
                    if (r_cnt == 4'd0) begin
                        r_state <= M_FOC;
                    end
                end
                M_FOC: begin
                    r_acc   <= r_acc + {{8{r_focus[23]}}, r_focus, 16'd0};
                    r_state <= M_SCL;
                end
                M_SCL: begin
                    r_acc   <= {r_acc[43:0], 4'd0} + {r_acc[45:0], 2'd0};
                    r_state <= M_RND;
                end
                M_RND: begin
                    r_target <= w_round[47:16];
                    r_state  <= M_DONE;
                end
                M_DONE: begin
                    r_state <= M_IDLE;
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_res.done   = (r_state == M_DONE);
    assign o_res.target = r_target;

endmodule

// ----- design/ttfs_div.sv -----
module ttfs_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [31:0]  i_target,
    input  logic signed [39:0]  i_pos,
    input  logic [15:0]         i_fwd,
    input  logic [15:0]         i_back,
    output ttfs_pkg::t_div_res  o_res
);

    localparam int W_NUM = 42;

    localparam logic [2:0] D_IDLE = 3'd0;
    localparam logic [2:0] D_PREP = 3'd1;
    localparam logic [2:0] D_ITER = 3'd2;
    localparam logic [2:0] D_FIN  = 3'd3;
    localparam logic [2:0] D_DONE = 3'd4;

    localparam logic [5:0] LAST_BIT = 6'(W_NUM - 1);

    logic [2:0]          r_state;
    logic signed [40:0]  r_diff;
    logic                r_neg;
    logic [15:0]         r_size;
    logic [W_NUM-1:0]    r_num;
    logic [16:0]         r_rem;
    logic [23:0]         r_quo;
    logic                r_ovf;
    logic [5:0]          r_cnt;
    logic signed [23:0]  r_steps;

    logic signed [40:0]  w_diff;
    logic [15:0]         w_size;
    logic signed [42:0]  w_twice;
    logic signed [42:0]  w_sz43;
    logic signed [42:0]  w_num;
    logic [17:0]         w_rem_sh;
    logic [17:0]         w_dvs;
    logic                w_ge;
    logic [17:0]         w_rem_nx;
    logic                w_pos_big;
    logic                w_neg_big;

    assign w_diff = {{9{i_target[31]}}, i_target} - {i_pos[39], i_pos};
    always_comb begin
        w_size = w_diff[40] ? i_back : i_fwd;
        if (w_size == 16'd0) begin
            w_size = 16'd1;
        end
    end

    // Numerator of the rounded quotient: twice the magnitude plus the size.
    assign w_twice = {r_diff[40], r_diff, 1'b0};
    assign w_sz43  = {27'd0, r_size};
    assign w_num   = r_neg ? w_sz43 - w_twice : w_twice + w_sz43;

    assign w_rem_sh = {r_rem, r_num[W_NUM-1]};
    assign w_dvs    = {1'b0, r_size, 1'b0};
    assign w_ge     = (w_rem_sh >= w_dvs);
    assign w_rem_nx = w_ge ? w_rem_sh - w_dvs : w_rem_sh;

    assign w_pos_big = r_ovf | r_quo[23];
    assign w_neg_big = r_ovf | (r_quo[23] & (|r_quo[22:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_diff  <= w_diff;
                        r_neg   <= w_diff[40];
                        r_size  <= w_size;
                        r_state <= D_PREP;
                    end
                end
                D_PREP: begin
                    r_num   <= w_num[W_NUM-1:0];
                    r_rem   <= 17'd0;
                    r_quo   <= 24'd0;
                    r_ovf   <= 1'b0;
                    r_cnt   <= LAST_BIT;
                    r_state <= D_ITER;
                end
                D_ITER: begin
                    // Restoring division, one quotient bit a cycle; bits that
                    // leave the top of the quotient only mark saturation.
                    r_rem <= w_rem_nx[16:0];
                    r_num <= {r_num[W_NUM-2:0], 1'b0};
                    r_ovf <= r_ovf | r_quo[23];
                    r_quo <= {r_quo[22:0], w_ge};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_state <= D_FIN;
                    end
                end
                D_FIN: begin
                    if (r_neg) begin
                        r_steps <= w_neg_big ? ttfs_pkg::V24_MIN : 24'sd0 - $signed(r_quo);
                    end else begin
                        r_steps <= w_pos_big ? ttfs_pkg::V24_MAX : $signed(r_quo);
                    end
                    r_state <= D_DONE;
                end
                D_DONE: begin
                    r_state <= D_IDLE;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    assign o_res.done  = (r_state == D_DONE);
    assign o_res.steps = r_steps;
    assign o_res.size  = r_size;

endmodule
